>>> rtl/pci_pkg.sv
// Shared types and constants for the palette color indexer.
`default_nettype none

package pci_pkg;

  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic   active;
    color_t color;
    logic   done;
    logic   added;
    index_t index;
  } token_t;

endpackage

`default_nettype wire

>>> rtl/pci_pixel_if.sv
// Valid/ready channel that carries one input pixel item.
`default_nettype none

interface pci_pixel_if import pci_pkg::*;;
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  logic  first_pixel;

  modport source (output valid, red, green, blue, first_pixel, input ready);
  modport sink (input valid, red, green, blue, first_pixel, output ready);
endinterface

`default_nettype wire

>>> rtl/pci_result_if.sv
// Valid/ready channel that carries one palette lookup result item.
`default_nettype none

interface pci_result_if import pci_pkg::*;;
  logic   valid;
  logic   ready;
  index_t color_index;
  logic   newly_added;
  logic   palette_full;
  count_t entry_count;

  modport source (output valid, color_index, newly_added, palette_full, entry_count,
                  input ready);
  modport sink (input valid, color_index, newly_added, palette_full, entry_count,
                output ready);
endinterface

`default_nettype wire

>>> rtl/pci_cell.sv
// One palette cell: holds one entry and compares or appends the passing search token.
`default_nettype none

module pci_cell import pci_pkg::*; #(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [CNT_W-1:0] count,
  input  token_t           tok_in,
  output token_t           tok_out
);

  color_t entry;
  token_t tok_next;
  logic   searching;
  logic   hit;
  logic   append;

  always_comb begin
    searching = tok_in.active && !tok_in.done;
    hit       = searching && (CNT_W'(CELL_INDEX) < count) && (entry == tok_in.color);
    append    = searching && (CNT_W'(CELL_INDEX) == count);
    tok_next  = tok_in;
    if (hit || append) begin
      tok_next.done  = 1'b1;
      tok_next.index = INDEX_W'(CELL_INDEX);
    end
    if (append) begin
      tok_next.added = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && append) begin
      entry <= tok_in.color;
    end
  end

endmodule

`default_nettype wire

>>> rtl/palette_color_indexer.sv
// Top level of the palette color indexer: a chain of entry cells and the result register.
// Each accepted pixel item passes through every cell register and then the result register.
// A new pixel item is accepted only after the previous one reaches the result register.
// The search token moves one cell per cycle while the result output is not stalled.
// Reset empties the palette and the pipeline; entry contents are not cleared.
`default_nettype none

module palette_color_indexer import pci_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  pci_pixel_if.sink           pixel,
  pci_result_if.source        result
);

  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  token_t             tok [PALETTE_DEPTH+1];
  token_t             tail;
  logic               busy;
  logic               accept;
  logic               advance;
  logic               deliver;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   count_cells;
  logic [CNT_W-1:0]   count_after;

  assign pixel.ready = !busy;
  assign accept      = pixel.valid && pixel.ready;
  assign tail        = tok[PALETTE_DEPTH];
  assign advance     = !(tail.active && result.valid && !result.ready);
  assign deliver     = advance && tail.active;
  assign count_cells = (accept && pixel.first_pixel) ? '0 : count_q;
  assign count_after = count_q + CNT_W'(tail.added);

  always_comb begin
    tok[0].active = accept;
    tok[0].color  = {pixel.red, pixel.green, pixel.blue};
    tok[0].done   = 1'b0;
    tok[0].added  = 1'b0;
    tok[0].index  = '0;
  end

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    pci_cell #(
      .CELL_INDEX (i),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .count   (count_cells),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      count_q      <= '0;
      result.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (deliver) begin
        busy <= 1'b0;
      end
      if (accept && pixel.first_pixel) begin
        count_q <= '0;
      end else if (deliver) begin
        count_q <= count_after;
      end
      if (deliver) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      result.color_index  <= tail.done ? tail.index : '0;
      result.newly_added  <= tail.added;
      result.palette_full <= !tail.done;
      result.entry_count  <= COUNT_W'(count_after);
    end
  end

  // A result never claims both a new entry and a full palette.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.newly_added && result.palette_full))
    else $error("result flags both newly added and palette full");

  // A full palette report only happens once every entry is in use.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.palette_full) |-> (result.entry_count == COUNT_W'(PALETTE_DEPTH)))
    else $error("palette full reported with free entries");

  // Only one item is in the cell chain at a time.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !pixel.ready)
    else $error("input ready right after an accepted item");

  // A new result only appears after an item was in flight.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(busy))
    else $error("result appeared with no item in flight");

endmodule

`default_nettype wire
